FILE: design/ftok_pkg.sv
// Package with the item types, class codes and lexer mode codes of the formula tokenizer.
`timescale 1ns / 1ps

package ftok_pkg;

   // Token class codes; the first four double as lexer mode codes.
   localparam logic [2:0] CLS_NONE     = 3'd0;
   localparam logic [2:0] CLS_NUMBER   = 3'd1;
   localparam logic [2:0] CLS_IDENT    = 3'd2;
   localparam logic [2:0] CLS_STRING   = 3'd3;
   localparam logic [2:0] CLS_OPERATOR = 3'd4;
   localparam logic [2:0] CLS_SPECIAL  = 3'd5;
   localparam logic [2:0] CLS_UNKNOWN  = 3'd6;

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_NUMBER = 2'd1;
   localparam logic [1:0] MODE_IDENT  = 2'd2;
   localparam logic [1:0] MODE_STRING = 2'd3;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_formula;
   } req_type;

   typedef struct packed {
      logic       close_before;
      logic [2:0] closed_class;
      logic       keep_char;
      logic [7:0] char_out;
      logic [2:0] char_class;
      logic       starts_token;
      logic       close_after;
   } rsp_type;

   // Byte categories handed from the classifier to the lexer core.
   typedef struct packed {
      logic is_space;
      logic is_digit;
      logic is_word;
      logic is_dot;
      logic is_quote;
      logic is_op;
      logic is_special;
   } byte_cat_type;

endpackage

FILE: design/ftok_classify.sv
// Byte classifier: sorts one formula byte into the categories the lexer needs.
`timescale 1ns / 1ps

module ftok_classify (
   input  logic [7:0]                 ch,
   output ftok_pkg::byte_cat_type     cat
);

   always_comb begin
      cat.is_space   = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
      cat.is_digit   = (ch >= 8'h30) && (ch <= 8'h39);
      cat.is_word    = ((ch >= 8'h41) && (ch <= 8'h5A)) ||
                       ((ch >= 8'h61) && (ch <= 8'h7A)) || (ch == 8'h5F);
      cat.is_dot     = (ch == 8'h2E);
      cat.is_quote   = (ch == 8'h22);
      cat.is_op      = (ch == 8'h2B) || (ch == 8'h2D) || (ch == 8'h2A) ||
                       (ch == 8'h2F) || (ch == 8'h5E) || (ch == 8'h3D) ||
                       (ch == 8'h3E) || (ch == 8'h3C);
      cat.is_special = (ch == 8'h28) || (ch == 8'h29) || (ch == 8'h2C) ||
                       (ch == 8'h3A);
   end

endmodule

FILE: design/ftok_lex.sv
// Lexer core: holds the two-bit mode and forms the result item for one byte.
`timescale 1ns / 1ps

module ftok_lex (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  ftok_pkg::req_type        item,
   input  ftok_pkg::byte_cat_type   cat,
   output ftok_pkg::rsp_type        result
);

   logic [1:0] lex_mode_ff;
   logic [1:0] lex_mode_in;
   logic [1:0] next_mode;
   logic       single;

   always_comb begin
      result              = '0;
      result.keep_char    = 1'b1;
      result.char_out     = item.ch;
      next_mode           = lex_mode_ff;
      single              = 1'b0;

      if (lex_mode_ff == ftok_pkg::MODE_STRING) begin
         result.char_class = ftok_pkg::CLS_STRING;
         if (cat.is_quote) begin
            result.close_after = 1'b1;
            next_mode          = ftok_pkg::MODE_IDLE;
         end
      end else if (cat.is_space) begin
         result.keep_char = 1'b0;
         if (lex_mode_ff != ftok_pkg::MODE_IDLE) begin
            result.close_before = 1'b1;
            result.closed_class = {1'b0, lex_mode_ff};
         end
         next_mode = ftok_pkg::MODE_IDLE;
      end else if (cat.is_digit && lex_mode_ff != ftok_pkg::MODE_IDLE) begin
         // Digits continue both numbers and identifiers.
         result.char_class = {1'b0, lex_mode_ff};
      end else if (cat.is_dot && lex_mode_ff == ftok_pkg::MODE_NUMBER) begin
         result.char_class = ftok_pkg::CLS_NUMBER;
      end else if (cat.is_word && lex_mode_ff == ftok_pkg::MODE_IDENT) begin
         result.char_class = ftok_pkg::CLS_IDENT;
      end else begin
         // The byte opens a new token, so any open token ends before it.
         if (lex_mode_ff != ftok_pkg::MODE_IDLE) begin
            result.close_before = 1'b1;
            result.closed_class = {1'b0, lex_mode_ff};
         end
         result.starts_token = 1'b1;
         if (cat.is_op) begin
            result.char_class = ftok_pkg::CLS_OPERATOR;
            single            = 1'b1;
         end else if (cat.is_digit) begin
            result.char_class = ftok_pkg::CLS_NUMBER;
            next_mode         = ftok_pkg::MODE_NUMBER;
         end else if (cat.is_word) begin
            result.char_class = ftok_pkg::CLS_IDENT;
            next_mode         = ftok_pkg::MODE_IDENT;
         end else if (cat.is_quote) begin
            result.char_class = ftok_pkg::CLS_STRING;
            next_mode         = ftok_pkg::MODE_STRING;
         end else if (cat.is_special) begin
            result.char_class = ftok_pkg::CLS_SPECIAL;
            single            = 1'b1;
         end else begin
            result.char_class = ftok_pkg::CLS_UNKNOWN;
            single            = 1'b1;
         end
         if (single) begin
            result.close_after = 1'b1;
            next_mode          = ftok_pkg::MODE_IDLE;
         end
      end

      // End of formula closes whatever token is still open with this byte.
      if (item.end_of_formula) begin
         if (result.keep_char && next_mode != ftok_pkg::MODE_IDLE) begin
            result.close_after = 1'b1;
         end
         next_mode = ftok_pkg::MODE_IDLE;
      end
   end

   assign lex_mode_in = advance ? next_mode : lex_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_mode_ff <= ftok_pkg::MODE_IDLE;
      end else begin
         lex_mode_ff <= lex_mode_in;
      end
   end

endmodule

FILE: design/formula_char_tokenizer_unit.sv
// Top level of the formula tokenizer: input register, lexer core and result register.
`timescale 1ns / 1ps

// Channel   Ports                              Payload
// request   req_valid, req_ready, req_item     ftok_pkg::req_type (byte, end flag)
// response  rsp_valid, rsp_ready, rsp_item     ftok_pkg::rsp_type (one per byte)
//
// One item per cycle while rsp_ready is held high. A byte sits in the input
// register, where the classifier and lexer core act on it, and is loaded into
// the result register when that register is empty or being read. A stall
// on rsp_ready holds the result register; req_ready drops only once the input
// register is full as well. Reset empties both registers and returns the lexer
// to idle.

module formula_char_tokenizer_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ftok_pkg::req_type   req_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ftok_pkg::rsp_type   rsp_item
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   ftok_pkg::req_type      in_item_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   ftok_pkg::rsp_type      out_item_ff;
   ftok_pkg::rsp_type      out_item_in;
   ftok_pkg::byte_cat_type cat;
   logic                   out_open;
   logic                   advance;

   assign out_open  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_open;
   assign req_ready = !in_valid_ff || out_open;

   ftok_classify u_classify (
      .ch  (in_item_ff.ch),
      .cat (cat)
   );

   ftok_lex u_lex (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cat     (cat),
      .result  (out_item_in)
   );

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = out_open ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

FILE: design/ftok_checker.sv
// Port checker for the formula tokenizer, bound to the top level.
`timescale 1ns / 1ps

module ftok_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input ftok_pkg::rsp_type   rsp_item
);

   // A result cannot appear in the cycle right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // An accepted item must be followed by a valid result on the response port.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("accepted item produced no result");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // Dropped whitespace carries no class, start or end mark.
   a_dropped_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.keep_char |->
         rsp_item.char_class == ftok_pkg::CLS_NONE &&
         !rsp_item.starts_token && !rsp_item.close_after)
      else $error("dropped byte carries token marks");

   // Only numbers and identifiers close ahead of a byte.
   a_close_before_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_item.close_before && (rsp_item.closed_class == ftok_pkg::CLS_NUMBER ||
                                    rsp_item.closed_class == ftok_pkg::CLS_IDENT)) ||
         (!rsp_item.close_before && rsp_item.closed_class == ftok_pkg::CLS_NONE))
      else $error("closed class does not match close mark");

endmodule

bind formula_char_tokenizer_unit ftok_checker u_ftok_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);
